// ===== design/hxfr_pkg.sv =====
`timescale 1ns / 1ps

package hxfr_pkg;

  localparam int PAYLOAD_BYTES = 4;
  localparam int WORD_W = 32;
  localparam int WORD_BYTES = WORD_W / 8;
  localparam int COUNT_W = 3;

  localparam logic [7:0] HDR_FIRST = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'hAA;
  localparam logic [7:0] TIMEOUT_RESET = 8'd15;
  localparam logic [7:0] IDLE_MAX = 8'hFF;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_HDR2  = 2'd1,
    PH_DATA  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ===== design/header_xor_frame_receiver_top.sv =====
`timescale 1ns / 1ps

// Frame receiver for a byte link with a 0x55 0xAA header, a payload and an
// XOR checksum byte. Each input beat is either a received byte or a one
// millisecond tick, chosen by action. A tick counts idle time; a partial frame
// is dropped once the idle count exceeds timeout_limit.
// Each good frame yields one output beat on payload_word, first payload byte
// in bits 7:0. Bad frames produce nothing.
// Throughput is one input beat per cycle while the frame queue is not full.
// An output beat follows the accepted checksum byte through the two-entry frame
// queue and then the output register.
// The input side stalls only when the frame queue is full, which happens when
// the output side holds off for long enough that two frames wait behind the
// output register. Input bytes and ticks that do not finish a frame are never
// held back otherwise.
// timeout_limit is written with timeout_limit_we and should change only while
// the block is idle. Reset returns it to 15, empties the queue and output
// register, and puts the receiver back to hunting for a header.
module header_xor_frame_receiver_top import hxfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              timeout_limit_we,
  input  logic [7:0]        timeout_limit,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic              action,
  input  logic [7:0]        rx_byte,
  output logic              word_valid,
  input  logic              word_ready,
  output logic [WORD_W-1:0] payload_word
);

  frame_t            frame;
  fifo_status_t      fifo_status;
  logic [WORD_W-1:0] head_word;
  logic              pop;

  hxfr_front u_front (
    .clk              (clk),
    .rst              (rst),
    .timeout_limit_we (timeout_limit_we),
    .timeout_limit    (timeout_limit),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .action           (action),
    .rx_byte          (rx_byte),
    .fifo_status      (fifo_status),
    .frame            (frame)
  );

  hxfr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .pop       (pop),
    .status    (fifo_status),
    .head_word (head_word)
  );

  hxfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .fifo_status  (fifo_status),
    .head_word    (head_word),
    .pop          (pop),
    .word_valid   (word_valid),
    .word_ready   (word_ready),
    .payload_word (payload_word)
  );

endmodule

// ===== design/hxfr_front.sv =====
`timescale 1ns / 1ps

module hxfr_front import hxfr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         timeout_limit_we,
  input  logic [7:0]   timeout_limit,
  input  logic         item_valid,
  output logic         item_ready,
  input  logic         action,
  input  logic [7:0]   rx_byte,
  input  fifo_status_t fifo_status,
  output frame_t       frame
);

  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]         running_xor, running_xor_next;
  logic [7:0]         idle_ticks, idle_ticks_next;
  logic [7:0]         limit;
  logic [7:0]         payload_store [PAYLOAD_BYTES];
  logic               store_shift;
  logic               accept;
  logic [COUNT_W:0]   count_inc;
  logic [WORD_W-1:0]  packed_word;

  assign item_ready = !fifo_status.full;
  assign accept = item_valid && item_ready;
  assign count_inc = {1'b0, byte_count} + 1'b1;

  // Bytes beyond the word are checked but not delivered; missing bytes read as zero.
  always_comb begin
    packed_word = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (i < PAYLOAD_BYTES) begin
        packed_word[8*i +: 8] = payload_store[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      byte_count  <= '0;
      running_xor <= '0;
      idle_ticks  <= '0;
      limit       <= TIMEOUT_RESET;
    end else begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      running_xor <= running_xor_next;
      idle_ticks  <= idle_ticks_next;
      if (timeout_limit_we) begin
        limit <= timeout_limit;
      end
    end
  end

  // The store fills as a shift line, so after a full payload entry 0 holds the first byte.
  always_ff @(posedge clk) begin
    if (store_shift) begin
      for (int i = 0; i < PAYLOAD_BYTES - 1; i++) begin
        payload_store[i] <= payload_store[i+1];
      end
      payload_store[PAYLOAD_BYTES-1] <= rx_byte;
    end
  end

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    running_xor_next = running_xor;
    idle_ticks_next  = idle_ticks;
    store_shift      = 1'b0;
    frame.valid      = 1'b0;
    frame.word       = packed_word;
    if (accept) begin
      if (action == ACT_TICK) begin
        if (idle_ticks != IDLE_MAX) begin
          idle_ticks_next = idle_ticks + 8'd1;
        end
        if (phase != PH_HUNT && idle_ticks_next > limit) begin
          phase_next      = PH_HUNT;
          byte_count_next = '0;
        end
      end else begin
        idle_ticks_next = '0;
        unique case (phase)
          PH_HUNT: begin
            if (rx_byte == HDR_FIRST) begin
              phase_next = PH_HDR2;
            end
          end
          PH_HDR2: begin
            if (rx_byte == HDR_SECOND) begin
              phase_next       = PH_DATA;
              byte_count_next  = '0;
              running_xor_next = '0;
            end else begin
              phase_next = PH_HUNT;
            end
          end
          PH_DATA: begin
            store_shift      = 1'b1;
            running_xor_next = running_xor ^ rx_byte;
            byte_count_next  = count_inc[COUNT_W-1:0];
            if (count_inc >= (COUNT_W+1)'(PAYLOAD_BYTES)) begin
              phase_next = PH_CHECK;
            end
          end
          PH_CHECK: begin
            phase_next      = PH_HUNT;
            byte_count_next = '0;
            frame.valid     = (rx_byte == running_xor);
          end
          default: begin
            phase_next = PH_HUNT;
          end
        endcase
      end
    end
  end

endmodule

// ===== design/hxfr_fifo.sv =====
`timescale 1ns / 1ps

module hxfr_fifo import hxfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  frame_t            frame,
  input  logic              pop,
  output fifo_status_t      status,
  output logic [WORD_W-1:0] head_word
);

  logic [WORD_W-1:0] entries [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign head_word    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (frame.valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({frame.valid, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid) begin
      entries[wr_ptr] <= frame.word;
    end
  end

endmodule

// ===== design/hxfr_back.sv =====
`timescale 1ns / 1ps

module hxfr_back import hxfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  fifo_status_t      fifo_status,
  input  logic [WORD_W-1:0] head_word,
  output logic              pop,
  output logic              word_valid,
  input  logic              word_ready,
  output logic [WORD_W-1:0] payload_word
);

  assign pop = !fifo_status.empty && (!word_valid || word_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (pop) begin
      word_valid <= 1'b1;
    end else if (word_ready) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      payload_word <= head_word;
    end
  end

endmodule
